// ===== sv/lzssd_pkg.sv =====
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared types and format constants for the LZSS decompressor.
// ----------------------------------------------------------------------------
package lzssd_pkg;

    localparam int RING_DEPTH   = 4096;
    localparam int RING_AW      = 12;
    localparam int LEN_W        = 5;
    localparam int MIN_MATCH    = 3;
    localparam int START_RESET  = 4078;
    localparam int FLAG_COUNT   = 8;

    typedef enum logic [1:0] {
        OP_FLAG  = 2'd0,
        OP_LIT   = 2'd1,
        OP_MLOW  = 2'd2,
        OP_MATCH = 2'd3
    } op_t;

    // one accepted stream byte, decoded
    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [7:0]         data;
        logic [RING_AW-1:0] pos;
        logic [LEN_W-1:0]   len;
        logic               file_start;
    } cmd_t;

    // one decompressed byte toward the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } emit_t;

endpackage

// ===== sv/lzssd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lzssd_parser.sv =====
// ----------------------------------------------------------------------------
// LZSS stream parser
// Tracks flag bits and match halves, decodes each accepted byte.
// ----------------------------------------------------------------------------
module lzssd_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    output lzssd_pkg::cmd_t cmd
);

    logic [7:0] flag_reg, flag_next;
    logic [3:0] left_reg, left_next;
    logic [7:0] low_reg, low_next;
    logic       half_reg, half_next;
    logic       start_reg, start_next;
    lzssd_pkg::op_t op;

    always_comb
    begin
        if (left_reg == 4'd0)
        begin
            op = lzssd_pkg::OP_FLAG;
        end
        else if (flag_reg[0])
        begin
            op = lzssd_pkg::OP_LIT;
        end
        else if (!half_reg)
        begin
            op = lzssd_pkg::OP_MLOW;
        end
        else
        begin
            op = lzssd_pkg::OP_MATCH;
        end
    end

    always_comb
    begin
        flag_next  = flag_reg;
        left_next  = left_reg;
        low_next   = low_reg;
        half_next  = half_reg;
        start_next = start_reg;
        if (accept)
        begin
            start_next = 1'b0;
            case (op)
                lzssd_pkg::OP_FLAG:
                begin
                    flag_next = in_byte;
                    left_next = 4'(lzssd_pkg::FLAG_COUNT);
                end
                lzssd_pkg::OP_LIT:
                begin
                    flag_next = {1'b0, flag_reg[7:1]};
                    left_next = left_reg - 4'd1;
                end
                lzssd_pkg::OP_MLOW:
                begin
                    low_next  = in_byte;
                    half_next = 1'b1;
                end
                lzssd_pkg::OP_MATCH:
                begin
                    flag_next = {1'b0, flag_reg[7:1]};
                    left_next = left_reg - 4'd1;
                    low_next  = 8'd0;
                    half_next = 1'b0;
                end
                default:
                begin
                    flag_next = flag_reg;
                end
            endcase
            if (in_last)
            begin
                flag_next  = 8'd0;
                left_next  = 4'd0;
                low_next   = 8'd0;
                half_next  = 1'b0;
                start_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg  <= 8'd0;
            left_reg  <= 4'd0;
            low_reg   <= 8'd0;
            half_reg  <= 1'b0;
            start_reg <= 1'b1;
        end
        else
        begin
            flag_reg  <= flag_next;
            left_reg  <= left_next;
            low_reg   <= low_next;
            half_reg  <= half_next;
            start_reg <= start_next;
        end
    end

    assign cmd.valid      = accept;
    assign cmd.op         = op;
    assign cmd.data       = in_byte;
    assign cmd.pos        = {in_byte[7:4], low_reg};
    assign cmd.len        = {1'b0, in_byte[3:0]} + lzssd_pkg::LEN_W'(lzssd_pkg::MIN_MATCH);
    assign cmd.file_start = start_reg;

endmodule

// ===== sv/lzssd_copy_engine.sv =====
// ----------------------------------------------------------------------------
// LZSS copy engine
// Sequencer around the history ring: clear pass, literal and match copy.
// ----------------------------------------------------------------------------
module lzssd_copy_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lzssd_pkg::cmd_t                cmd,
    input  logic [lzssd_pkg::RING_AW-1:0]  start_pos,
    input  logic                           out_free,
    output logic                           idle,
    output lzssd_pkg::emit_t               emit
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [lzssd_pkg::RING_AW-1:0] clr_reg, clr_next;
    logic [lzssd_pkg::RING_AW-1:0] wp_reg, wp_next;
    logic [lzssd_pkg::RING_AW-1:0] rp_reg, rp_next;
    logic [lzssd_pkg::LEN_W-1:0]   remain_reg, remain_next;
    logic [7:0]                    lit_reg, lit_next;
    logic                          lit_mode_reg, lit_mode_next;

    // shared address incrementer: read pointer in READ, write pointer otherwise
    logic [lzssd_pkg::RING_AW-1:0] inc_in, inc_out;

    logic                          ram_we, ram_re;
    logic [lzssd_pkg::RING_AW-1:0] ram_waddr;
    logic [7:0]                    ram_wdata, ram_rdata;
    logic [7:0]                    byte_val;

    assign inc_in   = (state_reg == ST_READ) ? rp_reg : wp_reg;
    assign inc_out  = inc_in + 1'b1;
    assign byte_val = lit_mode_reg ? lit_reg : ram_rdata;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        remain_next   = remain_reg;
        lit_next      = lit_reg;
        lit_mode_next = lit_mode_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = wp_reg;
        ram_wdata     = byte_val;
        emit.valid    = 1'b0;
        emit.data     = byte_val;
        emit.last     = (remain_reg == lzssd_pkg::LEN_W'(1));
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'd0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.file_start)
                    begin
                        wp_next = start_pos;
                    end
                    if (cmd.op == lzssd_pkg::OP_LIT)
                    begin
                        lit_next      = cmd.data;
                        lit_mode_next = 1'b1;
                        remain_next   = lzssd_pkg::LEN_W'(1);
                        state_next    = ST_EMIT;
                    end
                    else if (cmd.op == lzssd_pkg::OP_MATCH)
                    begin
                        rp_next       = cmd.pos;
                        lit_mode_next = 1'b0;
                        remain_next   = cmd.len;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                rp_next    = inc_out;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ram_we      = 1'b1;
                    emit.valid  = 1'b1;
                    wp_next     = inc_out;
                    remain_next = remain_reg - 1'b1;
                    state_next  = (remain_reg == lzssd_pkg::LEN_W'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            wp_reg       <= lzssd_pkg::RING_AW'(lzssd_pkg::START_RESET);
            rp_reg       <= '0;
            remain_reg   <= '0;
            lit_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            remain_reg   <= remain_next;
            lit_mode_reg <= lit_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg <= lit_next;
    end

    lzssd_ram #(
        .WIDTH(8),
        .DEPTH(lzssd_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    assign idle = (state_reg == ST_IDLE);

`ifndef SYNTH
    a_no_emit_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !emit.valid)
        else $error("byte emitted during ring clear");

    a_cmd_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> state_reg == ST_IDLE)
        else $error("request decoded while engine busy");

    a_emit_writes_back: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> ram_we && ram_waddr == wp_reg)
        else $error("emitted byte not written to ring");

    a_last_ends_copy: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid && emit.last |=> state_reg == ST_IDLE)
        else $error("copy continues after last byte");

    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_EMIT)
        else $error("read not followed by emit");
`endif

endmodule

// ===== sv/lzss_decompressor_core.sv =====
// ----------------------------------------------------------------------------
// LZSS decompressor core
// Byte-serial LZSS decoder with a 4096-byte history ring.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   --------  ---------------------  --------------------
//   in        in_valid / in_stall    in_byte, in_last
//   out       out_valid / out_stall  out_byte, out_last
//   cfg       cfg_valid / cfg_ready  cfg_data (ring start)
//
// Flag and first-match bytes are taken while the engine stays idle; a literal
// passes through the emit step; a match alternates read and emit steps (3..18
// bytes), reading and then writing the history ring per copied byte.
// After reset the ring is cleared to zero; in_stall is high meanwhile.
// Output stalls hold the copy in its emit step; cfg writes are always taken.
// ----------------------------------------------------------------------------
module lzss_decompressor_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_byte,
    output logic                           out_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lzssd_pkg::RING_AW-1:0]  cfg_data
);

    logic                          idle;
    logic                          accept;
    logic                          out_free;
    lzssd_pkg::cmd_t               cmd;
    lzssd_pkg::emit_t              emit;
    logic [lzssd_pkg::RING_AW-1:0] start_reg;
    logic                          ov_reg, ov_next;
    logic [7:0]                    ob_reg;
    logic                          ol_reg;

    assign in_stall  = !idle;
    assign accept    = in_valid && idle;
    assign cfg_ready = 1'b1;
    assign out_free  = !ov_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= lzssd_pkg::RING_AW'(lzssd_pkg::START_RESET);
        end
        else if (cfg_valid)
        begin
            start_reg <= cfg_data;
        end
    end

    lzssd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .cmd     (cmd)
    );

    lzssd_copy_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .start_pos (start_reg),
        .out_free  (out_free),
        .idle      (idle),
        .emit      (emit)
    );

    always_comb
    begin
        ov_next = ov_reg;
        if (emit.valid)
        begin
            ov_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            ob_reg <= emit.data;
            ol_reg <= emit.last;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;

endmodule

// ===== tb/sv/tb_lzss_decompressor_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZSS decompressor core testbench
// Feeds compressed files (directed cases, then random well-formed files with
// some truncated and noise files) under random input gaps and output stalls,
// across several ring start settings. A scoreboard expands every accepted
// stream byte into the plain bytes it should produce and compares them in
// order with the bytes the core emits.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [7:0] value;
    logic       last;
} stream_byte_t;

class decomp_scoreboard;
    logic [7:0]                    ring [lzssd_pkg::RING_DEPTH];
    logic [lzssd_pkg::RING_AW-1:0] start_pos;
    logic [lzssd_pkg::RING_AW-1:0] wr_pos;
    logic [7:0]                    flags;
    logic [3:0]                    flags_left;
    logic [7:0]                    low_byte;
    bit                            half_seen;
    bit                            file_start;
    stream_byte_t                  plain_bytes_q [$];
    int                            mismatch_cnt;

    function new();
        foreach (ring[i])
            ring[i] = 8'h00;
        start_pos    = lzssd_pkg::RING_AW'(lzssd_pkg::START_RESET);
        wr_pos       = lzssd_pkg::RING_AW'(lzssd_pkg::START_RESET);
        flags        = 8'h00;
        flags_left   = 4'd0;
        low_byte     = 8'h00;
        half_seen    = 1'b0;
        file_start   = 1'b1;
        mismatch_cnt = 0;
    endfunction

    function void set_start(logic [lzssd_pkg::RING_AW-1:0] v);
        start_pos = v;
    endfunction

    function void put_plain(logic [7:0] v);
        ring[wr_pos] = v;
        plain_bytes_q.push_back({v, 1'b0});
        wr_pos = wr_pos + 1'b1;
    endfunction

    function void use_flag();
        flags      = flags >> 1;
        flags_left = flags_left - 1'b1;
    endfunction

    // expand one accepted compressed byte into the plain bytes it causes
    function void expand_byte(logic [7:0] b, logic last);
        lzssd_pkg::op_t                op;
        logic [lzssd_pkg::RING_AW-1:0] src;
        int                            len;
        int                            n0;
        n0 = plain_bytes_q.size();
        if (file_start)
        begin
            wr_pos     = start_pos;
            file_start = 1'b0;
        end
        if (flags_left == 0)
            op = lzssd_pkg::OP_FLAG;
        else if (flags[0])
            op = lzssd_pkg::OP_LIT;
        else if (!half_seen)
            op = lzssd_pkg::OP_MLOW;
        else
            op = lzssd_pkg::OP_MATCH;
        case (op)
            lzssd_pkg::OP_FLAG:
            begin
                flags      = b;
                flags_left = 4'(lzssd_pkg::FLAG_COUNT);
            end
            lzssd_pkg::OP_LIT:
            begin
                put_plain(b);
                use_flag();
            end
            lzssd_pkg::OP_MLOW:
            begin
                low_byte  = b;
                half_seen = 1'b1;
            end
            default:
            begin
                src = {b[7:4], low_byte};
                len = int'(b[3:0]) + lzssd_pkg::MIN_MATCH;
                // byte by byte, so an overlapping copy repeats what it just wrote
                for (int i = 0; i < len; i++)
                begin
                    put_plain(ring[src]);
                    src = src + 1'b1;
                end
                half_seen = 1'b0;
                low_byte  = 8'h00;
                use_flag();
            end
        endcase
        if (plain_bytes_q.size() > n0)
            plain_bytes_q[plain_bytes_q.size() - 1].last = 1'b1;
        if (last)
        begin
            flags      = 8'h00;
            flags_left = 4'd0;
            low_byte   = 8'h00;
            half_seen  = 1'b0;
            file_start = 1'b1;
        end
    endfunction

    task report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    task check_byte(logic [7:0] b, logic last);
        stream_byte_t want;
        if (plain_bytes_q.size() == 0)
            report($sformatf("unexpected output byte %02h last=%0b", b, last));
        else
        begin
            want = plain_bytes_q.pop_front();
            if (b !== want.value)
                report($sformatf("out_byte %02h, want %02h", b, want.value));
            if (last !== want.last)
                report($sformatf("out_last %0b, want %0b (byte %02h)", last, want.last,
                                 want.value));
        end
    endtask
endclass

module tb_lzss_decompressor_core;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int IDLE_CYCLES   = 64;
    localparam int PHASE_ITEMS   = 95;
    localparam int LONG_HOLD     = 400;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [7:0]                    in_byte = 8'h00;
    logic                          in_last = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [7:0]                    out_byte;
    logic                          out_last;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [lzssd_pkg::RING_AW-1:0] cfg_data = '0;

    decomp_scoreboard              sb = new();
    stream_byte_t                  stim_q [$];
    logic [lzssd_pkg::RING_AW-1:0] cur_start = lzssd_pkg::RING_AW'(lzssd_pkg::START_RESET);
    int                            cycle_cnt = 0;
    bit                            long_hold_req = 1'b0;
    int                            hold_left = 0;
    int                            stall_mode = 0;
    int                            mode_left = 0;
    int                            period_cnt = 0;

    lzss_decompressor_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // request acceptance on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.expand_byte(in_byte, in_last);
            if (out_valid && !out_stall)
                sb.check_byte(out_byte, out_last);
        end
    end

    // receiver: a long hold on request, else stall modes of random duration
    always @(posedge clk)
    begin
        if (long_hold_req && hold_left == 0)
        begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            period_cnt = (period_cnt == 2) ? 0 : period_cnt + 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (period_cnt == 0);
            endcase
        end
    end

    task automatic push_item(logic [7:0] b, logic last);
        stim_q.push_back({b, last});
    endtask

    // one file: flag groups with random literals and matches, sometimes cut
    // short anywhere, sometimes plain noise
    task automatic gen_file();
        int                            first_idx;
        int                            cut;
        int                            pick;
        int                            k;
        logic [7:0]                    fl;
        logic [lzssd_pkg::RING_AW-1:0] wp;
        logic [lzssd_pkg::RING_AW-1:0] src;
        logic [3:0]                    lenf;
        first_idx = stim_q.size();
        wp = cur_start;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                push_item(8'($urandom), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 5))
            begin
                pick = $urandom_range(0, 7);
                fl = (pick == 0) ? 8'hff : (pick == 1) ? 8'h00 : 8'($urandom);
                push_item(fl, 1'b0);
                for (k = 0; k < 8; k++)
                begin
                    if (fl[k])
                    begin
                        push_item(8'($urandom), 1'b0);
                        wp = wp + 1'b1;
                    end
                    else
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick <= 5)
                            src = wp - lzssd_pkg::RING_AW'($urandom_range(1, 20));
                        else if (pick <= 7)
                            src = wp - lzssd_pkg::RING_AW'($urandom_range(1, 400));
                        else if (pick == 8)
                            src = lzssd_pkg::RING_AW'($urandom);
                        else
                            src = wp;
                        lenf = 4'($urandom);
                        push_item(src[7:0], 1'b0);
                        push_item({src[11:8], lenf}, 1'b0);
                        wp = wp + lzssd_pkg::RING_AW'(int'(lenf) + lzssd_pkg::MIN_MATCH);
                    end
                end
            end
        end
        if ($urandom_range(0, 6) == 0)
            cut = $urandom_range(first_idx, stim_q.size() - 1);
        else
            cut = stim_q.size() - 1;
        while (stim_q.size() > cut + 1)
            void'(stim_q.pop_back());
        stim_q[cut].last = 1'b1;
    endtask

    // sender: bursts of random length, random gaps between them
    task automatic send_items();
        int idx;
        int burst;
        int gap;
        int pick;
        idx = 0;
        while (idx < stim_q.size())
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && idx < stim_q.size())
            begin
                in_valid <= 1'b1;
                in_byte  <= stim_q[idx].value;
                in_last  <= stim_q[idx].last;
                @(posedge clk);
                while (in_stall)
                    @(posedge clk);
                idx++;
                burst--;
            end
            pick = $urandom_range(0, 9);
            gap = (pick <= 4) ? 0 : (pick <= 8) ? $urandom_range(1, 4) : $urandom_range(10, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                in_byte  <= 8'($urandom);
                in_last  <= 1'($urandom);
                repeat (gap)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        stim_q.delete();
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (sb.plain_bytes_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_start(logic [lzssd_pkg::RING_AW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_start(v);
        cur_start = v;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [lzssd_pkg::RING_AW-1:0] starts [4];
        starts[0] = '0;
        starts[1] = '1;
        starts[2] = lzssd_pkg::RING_AW'($urandom_range(1, 4094));
        starts[3] = lzssd_pkg::RING_AW'(lzssd_pkg::START_RESET);

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // literal extremes, match at ring position 0 (shortest) and at the
        // top (longest, wrapping), then literals ending the file
        push_item(8'hf3, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'ha5, 1'b0);
        push_item(8'h5a, 1'b0);
        push_item(8'h3c, 1'b0);
        push_item(8'hc3, 1'b1);
        // run-length copy overlapping its own output, file ends on a match's
        // first byte
        push_item(8'h01, 1'b0);
        push_item(8'h77, 1'b0);
        push_item(8'hee, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'h12, 1'b1);
        // file that is only a flag byte
        push_item(8'haa, 1'b1);
        // file ends on a complete match
        push_item(8'h00, 1'b0);
        push_item(8'h10, 1'b0);
        push_item(8'h25, 1'b1);
        send_items();
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            write_start(starts[p]);
            while (stim_q.size() < PHASE_ITEMS)
                gen_file();
            if (p == 1)
                long_hold_req = 1'b1;
            send_items();
            wait_idle();
        end

        if (sb.mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
